FILE: sv/ggpc_pkg.sv
package ggpc_pkg;

   // Number of CORDIC micro-rotations; range 8 to 24.
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;

   // Integer square root of a 33-bit sum gives a 17-bit root, one bit per cell.
   localparam int SQRT_BITS = 17;
   localparam int CHAIN_LEN = (CORDIC_STEPS > SQRT_BITS) ? CORDIC_STEPS : SQRT_BITS;
   localparam int STEP_W    = $clog2(CHAIN_LEN);

   localparam int POS_W   = 16;
   localparam int DIFF_W  = 17;
   localparam int HEAD_W  = 15;
   localparam int XY_FRAC = 12;
   localparam int XY_W    = 32;
   localparam int Z_W     = 24;
   localparam int SQ_W    = 33;
   localparam int ROOT_W  = 17;
   localparam int ERR_W   = 15;
   localparam int GAIN_W  = 12;
   localparam int TOL_W   = 15;
   localparam int LIN_W   = 15;
   localparam int ANG_W   = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARRIVAL_TOL  = 2'd2;

   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET  = 12'd256;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 12'd512;
   localparam logic [TOL_W-1:0]  ARRIVAL_TOL_RESET  = 15'd26;

   localparam logic signed [Z_W-1:0]    PI_Q20     = 24'sd3294199;
   localparam logic signed [DIFF_W-1:0] PI_Q12     = 17'sd12868;
   localparam logic signed [DIFF_W-1:0] TWO_PI_Q12 = 17'sd25736;

   // One beat moving down the cell chain: CORDIC vector, angle, root and remainder.
   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic [SQ_W-1:0]          rem;
      logic [ROOT_W-1:0]        root;
      logic signed [HEAD_W-1:0] heading;
   } cell_beat_type;

   typedef struct packed {
      logic [LIN_W-1:0]        linear_velocity;
      logic signed [ANG_W-1:0] angular_velocity;
      logic                    arrived;
   } rsp_beat_type;

   // atan(2^-i) in Q.20 radians, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q20(input logic [STEP_W-1:0] step);
      logic signed [Z_W-1:0] value;
      case (int'(step))
         0:  value = 24'sd823550;
         1:  value = 24'sd486170;
         2:  value = 24'sd256879;
         3:  value = 24'sd130396;
         4:  value = 24'sd65451;
         5:  value = 24'sd32757;
         6:  value = 24'sd16383;
         7:  value = 24'sd8192;
         8:  value = 24'sd4096;
         9:  value = 24'sd2048;
         10: value = 24'sd1024;
         11: value = 24'sd512;
         12: value = 24'sd256;
         13: value = 24'sd128;
         14: value = 24'sd64;
         15: value = 24'sd32;
         16: value = 24'sd16;
         17: value = 24'sd8;
         18: value = 24'sd4;
         19: value = 24'sd2;
         20: value = 24'sd1;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

FILE: sv/ggpc_cell.sv
module ggpc_cell
   import ggpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [STEP_W-1:0] step,
   input  cell_beat_type     up,
   output cell_beat_type     down
);

   cell_beat_type          beat_ff;
   cell_beat_type          beat_in;
   logic signed [XY_W-1:0] x_shift;
   logic signed [XY_W-1:0] y_shift;
   logic [STEP_W-1:0]      bit_pos;
   logic [SQ_W+1:0]        trial;
   logic [SQ_W+1:0]        rem_wide;

   assign x_shift  = up.x >>> step;
   assign y_shift  = up.y >>> step;
   assign bit_pos  = STEP_W'(SQRT_BITS - 1) - step;
   // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
   assign trial    = ({{(SQ_W + 2 - ROOT_W){1'b0}}, up.root} << (bit_pos + 1))
                   + ((SQ_W + 2)'(1) << (2 * bit_pos));
   assign rem_wide = {2'b00, up.rem};

   always_comb begin
      beat_in = up;
      // one micro-rotation, driving y toward zero
      if (step < STEP_W'(CORDIC_STEPS)) begin
         if (!up.y[XY_W-1]) begin
            beat_in.x = up.x + y_shift;
            beat_in.y = up.y - x_shift;
            beat_in.z = up.z + atan_q20(step);
         end else begin
            beat_in.x = up.x - y_shift;
            beat_in.y = up.y + x_shift;
            beat_in.z = up.z - atan_q20(step);
         end
      end
      // one root bit, most significant first
      if (step < STEP_W'(SQRT_BITS)) begin
         if (rem_wide >= trial) begin
            beat_in.rem  = SQ_W'(rem_wide - trial);
            beat_in.root = up.root | (ROOT_W'(1) << bit_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign down = beat_ff;

endmodule

FILE: sv/ggpc_front.sv
module ggpc_front
   import ggpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [POS_W-1:0]  target_x,
   input  logic signed [POS_W-1:0]  target_y,
   input  logic signed [POS_W-1:0]  current_x,
   input  logic signed [POS_W-1:0]  current_y,
   input  logic signed [HEAD_W-1:0] current_heading,
   output cell_beat_type            beat
);

   logic                       valid_ff;
   logic signed [DIFF_W-1:0]   dx_ff;
   logic signed [DIFF_W-1:0]   dy_ff;
   logic signed [HEAD_W-1:0]   heading_ff;
   logic signed [DIFF_W-1:0]   dx_in;
   logic signed [DIFF_W-1:0]   dy_in;
   logic signed [2*DIFF_W-1:0] dx_sq;
   logic signed [2*DIFF_W-1:0] dy_sq;
   logic signed [XY_W-1:0]     x_scaled;
   logic signed [XY_W-1:0]     y_scaled;

   assign dx_in = DIFF_W'(target_x) - DIFF_W'(current_x);
   assign dy_in = DIFF_W'(target_y) - DIFF_W'(current_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         heading_ff <= current_heading;
      end
   end

   assign dx_sq    = dx_ff * dx_ff;
   assign dy_sq    = dy_ff * dy_ff;
   assign x_scaled = {{(XY_W - DIFF_W - XY_FRAC){dx_ff[DIFF_W-1]}}, dx_ff, {XY_FRAC{1'b0}}};
   assign y_scaled = {{(XY_W - DIFF_W - XY_FRAC){dy_ff[DIFF_W-1]}}, dy_ff, {XY_FRAC{1'b0}}};

   always_comb begin
      beat.valid   = valid_ff;
      beat.zero    = (dx_ff == '0) && (dy_ff == '0);
      beat.rem     = SQ_W'(dx_sq + dy_sq);
      beat.root    = '0;
      beat.heading = heading_ff;
      beat.x       = x_scaled;
      beat.y       = y_scaled;
      beat.z       = '0;
      // left half plane: turn by pi first so the rotations converge
      if (dx_ff[DIFF_W-1]) begin
         beat.x = -x_scaled;
         beat.y = -y_scaled;
         beat.z = dy_ff[DIFF_W-1] ? -PI_Q20 : PI_Q20;
      end
   end

endmodule

FILE: sv/ggpc_back.sv
module ggpc_back
   import ggpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cell_beat_type     beat,
   input  logic [GAIN_W-1:0] linear_gain,
   input  logic [GAIN_W-1:0] angular_gain,
   input  logic [TOL_W-1:0]  arrival_tolerance,
   output logic              res_valid,
   output rsp_beat_type      res
);

   localparam int LIN_PROD_W = GAIN_W + ROOT_W;
   localparam int ANG_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int LIN_Q_W    = LIN_PROD_W + 1 - 8;
   localparam int ANG_Q_W    = ANG_PROD_W + 1 - 8;

   logic signed [Z_W-1:0]        z_round;
   logic signed [DIFF_W-1:0]     bearing;
   logic signed [DIFF_W-1:0]     err_raw;
   logic signed [DIFF_W-1:0]     err_once;
   logic signed [DIFF_W-1:0]     err_wrap;

   logic                         p1_valid_ff;
   logic signed [ERR_W-1:0]      err_ff;
   logic [ROOT_W-1:0]            dist_ff;

   logic                         p2_valid_ff;
   logic [LIN_PROD_W-1:0]        lin_prod_ff;
   logic signed [ANG_PROD_W-1:0] ang_prod_ff;
   logic                         arrived_ff;
   logic [LIN_PROD_W-1:0]        lin_prod_in;
   logic signed [ANG_PROD_W-1:0] ang_prod_in;

   logic [LIN_PROD_W:0]          lin_sum;
   logic [LIN_Q_W-1:0]           lin_q;
   logic signed [ANG_PROD_W:0]   ang_sum;
   logic signed [ANG_Q_W-1:0]    ang_q;

   // bearing rounded from Q.20 to Q3.12
   assign z_round = beat.z + Z_W'(128);
   assign bearing = beat.zero ? '0 : DIFF_W'($signed(z_round[Z_W-1:8]));
   assign err_raw = bearing - DIFF_W'(beat.heading);

   always_comb begin
      err_once = err_raw;
      if (err_raw > PI_Q12) begin
         err_once = err_raw - TWO_PI_Q12;
      end else if (err_raw < -PI_Q12) begin
         err_once = err_raw + TWO_PI_Q12;
      end
      err_wrap = err_once;
      if (err_once > PI_Q12) begin
         err_wrap = err_once - TWO_PI_Q12;
      end else if (err_once < -PI_Q12) begin
         err_wrap = err_once + TWO_PI_Q12;
      end
   end

   assign lin_prod_in = linear_gain * dist_ff;
   assign ang_prod_in = $signed({1'b0, angular_gain}) * err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= beat.valid;
         p2_valid_ff <= p1_valid_ff;
      end
      if (advance) begin
         err_ff      <= ERR_W'(err_wrap);
         dist_ff     <= beat.root;
         lin_prod_ff <= lin_prod_in;
         ang_prod_ff <= ang_prod_in;
         arrived_ff  <= dist_ff <= ROOT_W'(arrival_tolerance);
      end
   end

   // round, then saturate
   assign lin_sum = {1'b0, lin_prod_ff} + (LIN_PROD_W + 1)'(128);
   assign lin_q   = lin_sum[LIN_PROD_W:8];
   assign ang_sum = (ANG_PROD_W + 1)'(ang_prod_ff) + (ANG_PROD_W + 1)'(128);
   assign ang_q   = ang_sum[ANG_PROD_W:8];

   always_comb begin
      res.arrived = arrived_ff;
      if (lin_q > LIN_Q_W'({LIN_W{1'b1}})) begin
         res.linear_velocity = {LIN_W{1'b1}};
      end else begin
         res.linear_velocity = LIN_W'(lin_q);
      end
      if (ang_q > ANG_Q_W'(32767)) begin
         res.angular_velocity = 16'sh7fff;
      end else if (ang_q < -ANG_Q_W'(32768)) begin
         res.angular_velocity = 16'sh8000;
      end else begin
         res.angular_velocity = ANG_W'(ang_q);
      end
   end

   assign res_valid = p2_valid_ff;

   a_err_wrapped: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (err_ff <= ERR_W'(PI_Q12)) && (err_ff >= -ERR_W'(PI_Q12)))
      else $error("heading error left the wrapped range");

   a_p1_to_p2: assert property (@(posedge clock) disable iff (reset)
      advance && p1_valid_ff |=> p2_valid_ff)
      else $error("beat lost between back stages");

endmodule

FILE: sv/go_to_goal_p_controller.sv
// Go-to-goal proportional controller. Each request beat carries a target point and the
// robot pose (positions signed Q8.8, heading signed Q3.12 rad); one response beat comes
// back per request with linear velocity = linear_gain * distance (Q8.8, capped at 32767),
// angular velocity = angular_gain * wrapped heading error (Q4.12, saturated both ways) and
// arrived = distance <= arrival_tolerance. Distance is the floor integer square root of
// dx^2 + dy^2; the bearing comes from CORDIC vectoring. A new request is taken every
// cycle while req_stall is low. A beat passes one input stage, a chain with one cell
// per CORDIC step or root bit, two back-end stages and the output register. req_stall
// rises only while the output skid slot is full, i.e. when rsp_stall holds a result in
// the output register with another right behind it. Gains and tolerance are
// written over the csr port (index 0 linear gain, 1 angular gain, 2 tolerance, others
// ignored); write them only while no beats are in flight. csr_ready is always high.
module go_to_goal_p_controller
   import ggpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [POS_W-1:0]      req_target_x,
   input  logic signed [POS_W-1:0]      req_target_y,
   input  logic signed [POS_W-1:0]      req_current_x,
   input  logic signed [POS_W-1:0]      req_current_y,
   input  logic signed [HEAD_W-1:0]     req_current_heading,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [LIN_W-1:0]             rsp_linear_velocity,
   output logic signed [ANG_W-1:0]      rsp_angular_velocity,
   output logic                         rsp_arrived,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   logic [GAIN_W-1:0] linear_gain_ff;
   logic [GAIN_W-1:0] angular_gain_ff;
   logic [TOL_W-1:0]  arrival_tol_ff;

   logic              advance;
   cell_beat_type     link [CHAIN_LEN+1];

   logic              res_valid;
   rsp_beat_type      res;

   // output register plus one skid slot
   rsp_beat_type      out_ff;
   rsp_beat_type      out_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_beat_type      skid_ff;
   rsp_beat_type      skid_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic              out_free;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff  <= LINEAR_GAIN_RESET;
         angular_gain_ff <= ANGULAR_GAIN_RESET;
         arrival_tol_ff  <= ARRIVAL_TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINEAR_GAIN:  linear_gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_ANGULAR_GAIN: angular_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_ARRIVAL_TOL:  arrival_tol_ff  <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline ----------------
   // Whole pipe moves together; it freezes only while the skid slot holds a beat.
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   ggpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .target_x        (req_target_x),
      .target_y        (req_target_y),
      .current_x       (req_current_x),
      .current_y       (req_current_y),
      .current_heading (req_current_heading),
      .beat            (link[0])
   );

   // Cell j does CORDIC step j and root bit (SQRT_BITS-1-j) where those exist.
   for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_chain
      ggpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .step    (STEP_W'(j)),
         .up      (link[j]),
         .down    (link[j+1])
      );
   end

   ggpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .beat              (link[CHAIN_LEN]),
      .linear_gain       (linear_gain_ff),
      .angular_gain      (angular_gain_ff),
      .arrival_tolerance (arrival_tol_ff),
      .res_valid         (res_valid),
      .res               (res)
   );

   // ---------------- output / skid ----------------
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // pipe is frozen; drain the parked beat first
         if (out_free) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (out_free) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_linear_velocity  = out_ff.linear_velocity;
   assign rsp_angular_velocity = out_ff.angular_velocity;
   assign rsp_arrived          = out_ff.arrived;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full with empty output register");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid slot did not drain");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && out_valid_ff && rsp_stall && res_valid |=> skid_valid_ff)
      else $error("result beat dropped while output stalled");

endmodule

FILE: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ggpc_pkg::*;

   // Cycles with no beat on any channel before the run is called hung. The slowest
   // correct gap is a random sender pause plus the pipeline plus a random response stall.
   localparam int IDLE_LIMIT   = 2000;
   // Settle time after the last response, a bit over the pipeline depth.
   localparam int DRAIN_CYCLES = CHAIN_LEN + 16;
   // Index past the register list; the block must ignore writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 12'hFFF;
   localparam logic [TOL_W-1:0]  TOL_MAX  = 15'h7FFF;
   localparam logic signed [HEAD_W-1:0] HEAD_PI = 15'sd12868;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [POS_W-1:0]  req_target_x = '0;
   logic signed [POS_W-1:0]  req_target_y = '0;
   logic signed [POS_W-1:0]  req_current_x = '0;
   logic signed [POS_W-1:0]  req_current_y = '0;
   logic signed [HEAD_W-1:0] req_current_heading = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LIN_W-1:0]         rsp_linear_velocity;
   logic signed [ANG_W-1:0]  rsp_angular_velocity;
   logic                     rsp_arrived;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // Shadow copy of the gain / tolerance registers.
   logic [GAIN_W-1:0] lin_gain = LINEAR_GAIN_RESET;
   logic [GAIN_W-1:0] ang_gain = ANGULAR_GAIN_RESET;
   logic [TOL_W-1:0]  arr_tol  = ARRIVAL_TOL_RESET;

   // Drive commands still owed by the block, oldest first.
   rsp_beat_type expected_cmds[$];

   int  errors      = 0;
   int  idle_cycles = 0;
   int  rsp_hold    = 0;
   // When set, that side runs back to back with no idle cycles.
   logic burst_req = 1'b0;
   logic burst_rsp = 1'b0;

   go_to_goal_p_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_target_x         (req_target_x),
      .req_target_y         (req_target_y),
      .req_current_x        (req_current_x),
      .req_current_y        (req_current_y),
      .req_current_heading  (req_current_heading),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_arrived          (rsp_arrived),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected drive command for one pose beat under the current register values.
   function automatic rsp_beat_type predict_command(
      input logic signed [POS_W-1:0]  tx,
      input logic signed [POS_W-1:0]  ty,
      input logic signed [POS_W-1:0]  cx,
      input logic signed [POS_W-1:0]  cy,
      input logic signed [HEAD_W-1:0] hd
   );
      rsp_beat_type cmd;
      longint dx, dy, sq, root, cand;
      longint x, y, z, xs, ys, step, bearing, err, lin, ang;
      longint atan_head [0:6];
      int     n;
      atan_head = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};
      dx = longint'(tx) - longint'(cx);
      dy = longint'(ty) - longint'(cy);
      sq = dx * dx + dy * dy;

      // floor sqrt, one root bit at a time from the top
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         cand = root | (64'sd1 <<< b);
         if (cand * cand <= sq) root = cand;
      end

      // CORDIC vectoring in Q.20; the left half plane is folded over by +/- pi first
      n = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
      if (dx == 0 && dy == 0) begin
         bearing = 0;
      end else begin
         x = dx * 4096;
         y = dy * 4096;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q20) : -longint'(PI_Q20);
            x = -x;
            y = -y;
         end
         for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            // past step 6 atan(2^-i) rounds to exactly 2^(20-i), and to 0 past step 20
            if (i < 7) step = atan_head[i];
            else if (i <= 20) step = 64'sd1 <<< (20 - i);
            else step = 0;
            if (y >= 0) begin
               x += ys;
               y -= xs;
               z += step;
            end else begin
               x -= ys;
               y += xs;
               z -= step;
            end
         end
         bearing = (z + 128) >>> 8;
      end

      err = bearing - longint'(hd);
      while (err > longint'(PI_Q12)) err -= longint'(TWO_PI_Q12);
      while (err < -longint'(PI_Q12)) err += longint'(TWO_PI_Q12);

      lin = (longint'(lin_gain) * root + 128) >>> 8;
      if (lin > 32767) lin = 32767;
      ang = (longint'(ang_gain) * err + 128) >>> 8;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;

      cmd.linear_velocity  = lin[LIN_W-1:0];
      cmd.angular_velocity = ang[ANG_W-1:0];
      cmd.arrived          = (root <= longint'(arr_tol));
      return cmd;
   endfunction

   // Send one pose beat after a random idle gap (none when burst_req is set); the prediction is queued on accept.
   task automatic send_pose(
      input logic signed [POS_W-1:0]  tx,
      input logic signed [POS_W-1:0]  ty,
      input logic signed [POS_W-1:0]  cx,
      input logic signed [POS_W-1:0]  cy,
      input logic signed [HEAD_W-1:0] hd
   );
      int gap;
      gap = burst_req ? 0 : int'($urandom_range(0, 12));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_target_x        <= tx;
      req_target_y        <= ty;
      req_current_x       <= cx;
      req_current_y       <= cy;
      req_current_heading <= hd;
      do @(posedge clock); while (req_stall);
      expected_cmds.push_back(predict_command(tx, ty, cx, cy, hd));
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cmds.size() != 0);
   endtask

   // Register write, only ever issued with the pipeline empty.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LINEAR_GAIN:  lin_gain = data[GAIN_W-1:0];
         CSR_ANGULAR_GAIN: ang_gain = data[GAIN_W-1:0];
         CSR_ARRIVAL_TOL:  arr_tol  = data[TOL_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: check every accepted beat, then draw the stall ahead of the next one.
   always @(posedge clock) begin
      rsp_beat_type want_cmd;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               want_cmd = expected_cmds.pop_front();
               if (rsp_linear_velocity !== want_cmd.linear_velocity) begin
                  $error("linear_velocity: expected %0d, actual %0d",
                         want_cmd.linear_velocity, rsp_linear_velocity);
                  errors++;
               end
               if (rsp_angular_velocity !== want_cmd.angular_velocity) begin
                  $error("angular_velocity: expected %0d, actual %0d",
                         want_cmd.angular_velocity, rsp_angular_velocity);
                  errors++;
               end
               if (rsp_arrived !== want_cmd.arrived) begin
                  $error("arrived: expected %0d, actual %0d",
                         want_cmd.arrived, rsp_arrived);
                  errors++;
               end
            end
            rsp_hold = burst_rsp ? 0 : int'($urandom_range(0, 12));
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset values: on-target, tolerance edge, quarter-turn bearing with error wrap.
   task automatic test_reset_gains();
      send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'sd0);
      send_pose(16'sd100, -16'sd50, 16'sd100, -16'sd50, HEAD_PI);
      send_pose(16'sd256, 16'sd0, 16'sd0, 16'sd0, 15'sd0);
      send_pose(16'sd26, 16'sd0, 16'sd0, 16'sd0, 15'sd0);
      send_pose(16'sd27, 16'sd0, 16'sd0, 16'sd0, 15'sd0);
      send_pose(16'sd0, 16'sd256, 16'sd0, 16'sd0, -HEAD_PI);
   endtask

   // Corner positions (full 17-bit deltas), left half-plane folds, heading out of range.
   task automatic test_field_extremes();
      send_pose(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, HEAD_PI);
      send_pose(-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -HEAD_PI);
      send_pose(-16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0, 15'sd0);
      send_pose(-16'sh8000, -16'sd1, 16'sh7FFF, 16'sd0, 15'sd0);
      send_pose(16'sd0, -16'sh8000, 16'sd0, 16'sh7FFF, 15'sd4000);
      send_pose(16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -15'sh4000);
      send_pose(-16'sd300, 16'sd300, 16'sd0, 16'sd0, 15'sh3FFF);
      send_pose(16'sh5555, -16'sh2AAB, -16'sh5556, 16'sh2AAA, -15'sh2AAB);
   endtask

   // Every register at its extremes, dropped upper bits, and the unused index.
   task automatic test_register_writes();
      write_csr(CSR_LINEAR_GAIN, CSR_DATA_W'(GAIN_MAX));
      write_csr(CSR_ANGULAR_GAIN, CSR_DATA_W'(GAIN_MAX));
      send_pose(16'sd0, 16'sd256, 16'sd0, 16'sd0, -HEAD_PI);
      send_pose(16'sd0, -16'sd256, 16'sd0, 16'sd0, HEAD_PI);
      send_pose(16'sh7FFF, 16'sd0, -16'sh8000, 16'sd0, 15'sd0);

      write_csr(CSR_LINEAR_GAIN, 15'd0);
      write_csr(CSR_ANGULAR_GAIN, 15'd0);
      write_csr(CSR_ARRIVAL_TOL, 15'd0);
      send_pose(16'sd10, 16'sd10, 16'sd10, 16'sd10, 15'sd0);
      send_pose(16'sd11, 16'sd10, 16'sd10, 16'sd10, 15'sd1000);

      write_csr(CSR_ARRIVAL_TOL, CSR_DATA_W'(TOL_MAX));
      send_pose(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 15'sd0);
      send_pose(16'sh7FFF, 16'sd1, -16'sd1, 16'sd0, 15'sd0);

      // bits above the 12-bit gains must fall away; index 3 must change nothing
      write_csr(CSR_LINEAR_GAIN, 15'h7123);
      write_csr(CSR_ANGULAR_GAIN, 15'h4321);
      write_csr(CSR_UNUSED, 15'h5A5A);
      send_pose(16'sd1000, -16'sd700, 16'sd0, 16'sd0, 15'sd2000);
      send_pose(16'sd0, 16'sd0, 16'sd30, 16'sd40, -15'sd2000);
   endtask

   // Random register setting per phase, extremes weighted in.
   task automatic write_random_setting();
      logic [GAIN_W-1:0] gain;
      logic [TOL_W-1:0]  tol;
      for (int r = 0; r < 2; r++) begin
         case ($urandom_range(0, 4))
            0: gain = '0;
            1: gain = GAIN_MAX;
            2: gain = (r == 0) ? LINEAR_GAIN_RESET : ANGULAR_GAIN_RESET;
            default: gain = GAIN_W'($urandom);
         endcase
         write_csr((r == 0) ? CSR_LINEAR_GAIN : CSR_ANGULAR_GAIN,
                   {3'($urandom), gain});
      end
      case ($urandom_range(0, 4))
         0: tol = '0;
         1: tol = TOL_MAX;
         2: tol = ARRIVAL_TOL_RESET;
         3: tol = TOL_W'($urandom_range(0, 512));
         default: tol = TOL_W'($urandom);
      endcase
      write_csr(CSR_ARRIVAL_TOL, tol);
      if ($urandom_range(0, 2) == 0) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
   endtask

   // Bulk random traffic: mixed geometry shapes, idle modes swapped per block.
   task automatic test_random_traffic();
      logic signed [POS_W-1:0]  tx, ty, cx, cy;
      logic signed [HEAD_W-1:0] hd;
      int off;
      for (int phase = 0; phase < 6; phase++) begin
         write_random_setting();
         for (int blk = 0; blk < 5; blk++) begin
            burst_req = ($urandom_range(0, 2) == 0);
            burst_rsp = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) wait_idle();
            for (int k = 0; k < 38; k++) begin
               cx = POS_W'($urandom);
               cy = POS_W'($urandom);
               case ($urandom_range(0, 9))
                  3, 4: begin
                     tx = POS_W'(int'(cx) + int'($urandom_range(0, 96)) - 48);
                     ty = POS_W'(int'(cy) + int'($urandom_range(0, 96)) - 48);
                  end
                  5: begin
                     tx = cx;
                     ty = POS_W'($urandom);
                  end
                  6: begin
                     tx = POS_W'($urandom);
                     ty = cy;
                  end
                  7: begin
                     off = int'($urandom_range(0, 2000)) - 1000;
                     tx  = POS_W'(int'(cx) + off);
                     ty  = $urandom_range(0, 1) ? POS_W'(int'(cy) + off)
                                                : POS_W'(int'(cy) - off);
                  end
                  8: begin
                     tx = cx;
                     ty = cy;
                  end
                  9: begin
                     // straddle the arrival threshold
                     tx = POS_W'(int'(cx) + int'($urandom_range(0, int'(arr_tol) + 2)));
                     ty = cy;
                  end
                  default: begin
                     tx = POS_W'($urandom);
                     ty = POS_W'($urandom);
                  end
               endcase
               if ($urandom_range(0, 7) == 0) hd = HEAD_W'($urandom);
               else hd = HEAD_W'(int'($urandom_range(0, 25736)) - 12868);
               send_pose(tx, ty, cx, cy, hd);
            end
         end
      end
      burst_req = 1'b0;
      burst_rsp = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_gains();
      test_field_extremes();
      test_register_writes();
      test_random_traffic();

      // drain, then give the pipeline time to show any stray beat
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/ggpc_pkg.sv
sv/ggpc_cell.sv
sv/ggpc_front.sv
sv/ggpc_back.sv
sv/go_to_goal_p_controller.sv
dv/tb.sv
